// ===== design/sdfc_pkg.sv =====
`timescale 1ns / 1ps
package sdfc_pkg;
  localparam int GRID_BITS = 5;
  localparam int GRID_DIM = 1 << GRID_BITS;
  localparam int PAD = 1;
  localparam int ADDR_W = 3 * GRID_BITS;
  localparam int BANK_W = ADDR_W - 3;
  localparam int CFG_AW = 5;
  // result buffer depth; credit counter and pointers are sized for 16
  localparam int QD = 16;

  localparam logic [2:0] REG_EXT_X = 3'd0;
  localparam logic [2:0] REG_EXT_Y = 3'd1;
  localparam logic [2:0] REG_EXT_Z = 3'd2;
  localparam logic [2:0] REG_LOD = 3'd3;
  localparam logic [2:0] REG_THR = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic signed [15:0] dist_t;
  typedef logic signed [23:0] coord_t;

  // per-axis mapping: lower index, upper index, weight
  typedef struct packed {
    logic [GRID_BITS-1:0] lo;
    logic [GRID_BITS-1:0] hi;
    logic [7:0] t;
  } axis_t;

  typedef struct packed {
    logic [5:0] ext_x;
    logic [5:0] ext_y;
    logic [5:0] ext_z;
    logic [2:0] lod;
  } cfg_t;

  // clamp extent register to 1..GRID_DIM, returns extent-1
  function automatic logic [GRID_BITS-1:0] ext_top(input logic [5:0] e);
    logic [GRID_BITS-1:0] r;
    if (e == 6'd0) r = '0;
    else if (e > 6'(GRID_DIM)) r = GRID_BITS'(GRID_DIM - 1);
    else r = GRID_BITS'(e - 6'd1);
    return r;
  endfunction

  function automatic axis_t axis_map(input coord_t c, input logic [2:0] lod,
                                     input logic [5:0] e);
    logic signed [24:0] s;
    logic [GRID_BITS-1:0] top;
    axis_t r;
    top = ext_top(e);
    s = 25'(c >>> lod) + 25'(PAD * 256);
    if (s < 0) s = '0;
    if (s > $signed({12'd0, top, 8'd0})) s = $signed({12'd0, top, 8'd0});
    r.lo = s[8 +: GRID_BITS];
    r.hi = (r.lo < top) ? r.lo + 1'b1 : top;
    r.t = s[7:0];
    return r;
  endfunction

  // rounded lerp, floor((a*(256-t)+b*t+128)/256)
  function automatic dist_t lerp(input dist_t a, input dist_t b, input logic [7:0] t);
    logic signed [25:0] n;
    n = 26'(a) * $signed({1'b0, 9'd256 - 9'(t)}) + 26'(b) * $signed({2'b0, t}) + 26'sd128;
    return dist_t'(n >>> 8);
  endfunction
endpackage

// ===== design/sdfc_if.sv =====
`timescale 1ns / 1ps
interface sdfc_in_if (input logic clk);
  logic valid;
  logic ready;
  logic op;
  logic [14:0] sample_addr;
  logic signed [15:0] sample_value;
  logic signed [23:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
  modport source (output valid, op, sample_addr, sample_value,
                  p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, input ready);
  modport sink (input valid, op, sample_addr, sample_value,
                p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, output ready);
endinterface

interface sdfc_out_if (input logic clk);
  logic valid;
  logic ready;
  logic keep_triangle;
  logic signed [15:0] highest_distance;
  modport source (output valid, keep_triangle, highest_distance, input ready);
  modport sink (input valid, keep_triangle, highest_distance, output ready);
endinterface

// ===== design/sdf_triangle_surface_cull.sv =====
`timescale 1ns / 1ps
// Triangle surface cull over a 32x32x32 Q8.8 distance grid held in eight
// banks (one per corner parity). A write beat stores one sample; a test beat
// produces one result beat. Three vertex lanes run side by side; the vertices
// read the shared banks one after another, so a test blocks the input until
// its last vertex has been read, while a write does not. Results wait in a
// 16-deep buffer; the input stalls when it could overflow. No clearing pass:
// unwritten entries read as don't-care.
module sdf_triangle_surface_cull (
  input  logic clk,
  input  logic rst,
  sdfc_in_if.sink  in_ch,
  sdfc_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [sdfc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  sdfc_pkg::cfg_t cfg;
  logic [14:0] thr;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{ext_x: 6'd32, ext_y: 6'd32, ext_z: 6'd32, lod: 3'd0};
      thr <= 15'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        sdfc_pkg::REG_EXT_X: cfg.ext_x <= pwdata[5:0];
        sdfc_pkg::REG_EXT_Y: cfg.ext_y <= pwdata[5:0];
        sdfc_pkg::REG_EXT_Z: cfg.ext_z <= pwdata[5:0];
        sdfc_pkg::REG_LOD: cfg.lod <= pwdata[2:0];
        sdfc_pkg::REG_THR: thr <= pwdata[14:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        sdfc_pkg::REG_EXT_X: prdata = 32'(cfg.ext_x);
        sdfc_pkg::REG_EXT_Y: prdata = 32'(cfg.ext_y);
        sdfc_pkg::REG_EXT_Z: prdata = 32'(cfg.ext_z);
        sdfc_pkg::REG_LOD: prdata = 32'(cfg.lod);
        sdfc_pkg::REG_THR: prdata = 32'(thr);
        default: prdata = '0;
      endcase
    end
  end

  // sequencer: phase counts vertices of a test beat
  logic [1:0] phase;
  logic [4:0] credit;   // results in flight or buffered
  logic busy, acc, issue;
  sdfc_pkg::coord_t hx [1:2], hy [1:2], hz [1:2];
  assign busy = (phase != 2'd0);
  assign in_ch.ready = !busy && (credit < 5'(sdfc_pkg::QD));
  assign acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) phase <= 2'd0;
    else if (acc && in_ch.op == sdfc_pkg::OP_TEST) phase <= 2'd1;
    else if (phase == 2'd2) phase <= 2'd0;
    else if (busy) phase <= phase + 2'd1;
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      hx[1] <= in_ch.p1_x; hy[1] <= in_ch.p1_y; hz[1] <= in_ch.p1_z;
      hx[2] <= in_ch.p2_x; hy[2] <= in_ch.p2_y; hz[2] <= in_ch.p2_z;
    end
  end

  // current vertex
  sdfc_pkg::coord_t vx, vy, vz;
  logic rd;
  always_comb begin
    unique case (phase)
      2'd1: begin vx = hx[1]; vy = hy[1]; vz = hz[1]; end
      2'd2: begin vx = hx[2]; vy = hy[2]; vz = hz[2]; end
      default: begin vx = in_ch.p0_x; vy = in_ch.p0_y; vz = in_ch.p0_z; end
    endcase
    rd = busy || (acc && in_ch.op == sdfc_pkg::OP_TEST);
  end

  // stage A: axis mapping registered
  sdfc_pkg::axis_t ax, ay, az;
  logic rd_a;
  logic [1:0] ph_a;
  always_ff @(posedge clk) begin
    if (rst) rd_a <= 1'b0;
    else rd_a <= rd;
    ax <= sdfc_pkg::axis_map(vx, cfg.lod, cfg.ext_x);
    ay <= sdfc_pkg::axis_map(vy, cfg.lod, cfg.ext_y);
    az <= sdfc_pkg::axis_map(vz, cfg.lod, cfg.ext_z);
    ph_a <= phase;
  end

  // banks: bank = {z0,y0,x0} parity, row = {z>>1, x>>1, y>>1} style
  logic [sdfc_pkg::BANK_W-1:0] raddr [8];
  logic [sdfc_pkg::BANK_W-1:0] waddr;
  logic [2:0] wbank;
  logic wen;
  sdfc_pkg::dist_t bank_q [8];
  logic [2:0] cbank [8];
  assign wen = acc && in_ch.op == sdfc_pkg::OP_WRITE;
  assign wbank = {in_ch.sample_addr[10], in_ch.sample_addr[0], in_ch.sample_addr[5]};
  assign waddr = {in_ch.sample_addr[14:11], in_ch.sample_addr[9:6], in_ch.sample_addr[4:1]};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic [4:0] x, y, z;
      x = ax.lo[0] == b[0] ? ax.lo : ax.hi;
      y = ay.lo[0] == b[1] ? ay.lo : ay.hi;
      z = az.lo[0] == b[2] ? az.lo : az.hi;
      raddr[b] = {z[4:1], x[4:1], y[4:1]};
    end
    // which bank holds corner k (k bits x,y,z)
    for (int k = 0; k < 8; k++) begin
      cbank[k][0] = k[0] ? ax.hi[0] : ax.lo[0];
      cbank[k][1] = k[1] ? ay.hi[0] : ay.lo[0];
      cbank[k][2] = k[2] ? az.hi[0] : az.lo[0];
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [15:0] q;
    sdfc_ram #(.WIDTH(16), .DEPTH(1 << sdfc_pkg::BANK_W)) u_ram (
      .clk(clk), .we(wen && wbank == 3'(b)), .waddr(waddr),
      .wdata(in_ch.sample_value), .raddr(raddr[b]), .rdata(q));
    assign bank_q[b] = sdfc_pkg::dist_t'(q);
  end

  // stage B: steer corners, capture weights
  logic [2:0] cb_b [8];
  logic [7:0] tx_b, ty_b, tz_b;
  logic rd_b;
  logic [1:0] ph_b;
  always_ff @(posedge clk) begin
    if (rst) rd_b <= 1'b0;
    else rd_b <= rd_a;
    cb_b <= cbank;
    tx_b <= ax.t; ty_b <= ay.t; tz_b <= az.t;
    ph_b <= ph_a;
  end

  sdfc_pkg::dist_t corner [8];
  always_comb begin
    for (int k = 0; k < 8; k++) corner[k] = bank_q[cb_b[k]];
  end

  // lanes: each vertex lane latches its corners in its phase
  sdfc_pkg::dist_t lc [3][8];
  logic [7:0] lt [3][3];
  logic go;
  sdfc_pkg::dist_t lv [3];
  always_ff @(posedge clk) begin
    if (rd_b) begin
      lc[ph_b] <= corner;
      lt[ph_b][0] <= tx_b; lt[ph_b][1] <= ty_b; lt[ph_b][2] <= tz_b;
    end
  end
  logic go_d, go_1, go_2, go_3;
  always_ff @(posedge clk) begin
    if (rst) begin
      go_d <= 1'b0; go_1 <= 1'b0; go_2 <= 1'b0; go_3 <= 1'b0;
    end else begin
      go_d <= rd_b && ph_b == 2'd2;
      go_1 <= go_d; go_2 <= go_1; go_3 <= go_2;
    end
  end
  assign go = go_d || go_1 || go_2;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    sdfc_lane u_lane (.clk(clk), .en(go), .c(lc[l]), .tx(lt[l][0]), .ty(lt[l][1]),
                      .tz(lt[l][2]), .v(lv[l]));
  end

  // merge stage: max of three and threshold compare
  sdfc_pkg::dist_t m01, best;
  logic keep;
  always_comb begin
    m01 = lv[0] > lv[1] ? lv[0] : lv[1];
    best = lv[2] > m01 ? lv[2] : m01;
    keep = 17'(best) >= -$signed({2'b0, thr});
  end

  // result buffer
  logic [16:0] q_mem [sdfc_pkg::QD];
  logic [3:0] wp, rp;
  logic [4:0] cnt;
  logic pop;
  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt != 5'd0;
  assign out_ch.keep_triangle = q_mem[rp][16];
  assign out_ch.highest_distance = q_mem[rp][15:0];
  always_ff @(posedge clk) begin
    if (go_3) q_mem[wp] <= {keep, best};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; credit <= '0;
    end else begin
      if (go_3) wp <= wp + 4'd1;
      if (pop) rp <= rp + 4'd1;
      cnt <= cnt + 5'(go_3) - 5'(pop);
      credit <= credit + 5'(acc && in_ch.op == sdfc_pkg::OP_TEST) - 5'(pop);
    end
  end
endmodule

// ===== design/sdfc_ram.sv =====
`timescale 1ns / 1ps
module sdfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/sdfc_lane.sv =====
`timescale 1ns / 1ps
// One interpolation lane: corner values in, trilinear sample out (3 stages).
module sdfc_lane (
  input  logic clk,
  input  logic en,
  input  sdfc_pkg::dist_t c [8],
  input  logic [7:0] tx,
  input  logic [7:0] ty,
  input  logic [7:0] tz,
  output sdfc_pkg::dist_t v
);
  sdfc_pkg::dist_t vx [4];
  sdfc_pkg::dist_t vy [2];
  logic [7:0] ty1, tz1, tz2;

  // corner index bits: [0]=x, [1]=y, [2]=z
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) vx[i] <= sdfc_pkg::lerp(c[2*i], c[2*i+1], tx);
      ty1 <= ty;
      tz1 <= tz;
      for (int i = 0; i < 2; i++) vy[i] <= sdfc_pkg::lerp(vx[2*i], vx[2*i+1], ty1);
      tz2 <= tz1;
      v <= sdfc_pkg::lerp(vy[0], vy[1], tz2);
    end
  end
endmodule

// ===== design/sdfc_checker.sv =====
`timescale 1ns / 1ps
module sdfc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input logic out_keep,
  input logic signed [15:0] out_dist,
  input logic pready
);
  // a test beat blocks the input while its other two vertices are read
  a_test_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op |=> !in_ready ##1 !in_ready)
    else $error("input accepted during vertex sequence");
  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("result after reset");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_dist) && $stable(out_keep))
    else $error("stalled result changed");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind sdf_triangle_surface_cull sdfc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_op(in_ch.op), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_keep(out_ch.keep_triangle), .out_dist(out_ch.highest_distance), .pready(pready));
